// File: rtl/core/hcgs_pkg.sv
// hcgs_pkg: shared constants and codes of the hop count graph search block
// no dependencies; used by the top level, the checker and the testbench

package hcgs_pkg;

  localparam int NODES_DEF      = 1024;
  localparam int MAX_DEGREE_DEF = 8;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_NODE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [2:0] REG_NODES_IN_USE = 3'd0;

endpackage

// File: rtl/core/hcgs_if.sv
// hcgs_in_if / hcgs_out_if: valid/ready channels of the graph search block
// no dependencies; node id width is set by the instantiating design

interface hcgs_in_if #(parameter int NODE_W = 10) ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] second_node;
  logic              use_target;

  modport source(output valid, mode, first_node, second_node, use_target, input ready);
  modport sink(input valid, mode, first_node, second_node, use_target, output ready);
endinterface

interface hcgs_out_if #(parameter int NODE_W = 10) ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [NODE_W:0]   hop_count;
  logic [NODE_W-1:0] predecessor;
  logic              has_predecessor;
  logic [NODE_W:0]   reached_count;
  logic              target_seen;

  modport source(output valid, status, hop_count, predecessor, has_predecessor,
                 reached_count, target_seen, input ready);
  modport sink(input valid, status, hop_count, predecessor, has_predecessor,
               reached_count, target_seen, output ready);
endinterface

// File: rtl/core/hcgs_ram.sv
// hcgs_ram: generic single write port, single read port ram, registered read
// no dependencies

module hcgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/hop_count_graph_search.sv
// hop_count_graph_search: breadth-first hop count search, one sequencer over
// neighbor, count, node-info and queue rams. clear sweeps counts, add edge reads and
// writes both counts, read fetches node info, search resets info then dequeues and scans.
// one transaction at a time; unless rejected, ready drops until the result is registered.
// after reset a sweep clears counts and node info before ready rises.
// depends on hcgs_pkg, hcgs_if.sv and hcgs_ram.sv

module hop_count_graph_search
  import hcgs_pkg::*;
#(
  parameter int NODES      = NODES_DEF,
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hcgs_in_if.sink     in_ch,
  hcgs_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NW  = $clog2(NODES);
  localparam int CW  = $clog2(MAX_DEGREE + 1);
  localparam int TD  = NODES * MAX_DEGREE;
  localparam int TAW = $clog2(TD);
  localparam int IW  = 2 * NW + 2;
  localparam logic [NW:0] UNREACHED = (NW+1)'(NODES);
  localparam logic [CW:0] MAXD      = (CW+1)'(MAX_DEGREE);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CLR, S_E_RA, S_E_RB, S_E_CHK, S_E_W2, S_RD, S_RD_W,
    S_BFS_CLR, S_BFS_SEED, S_DEQ, S_DQW, S_UW, S_SCAN, S_VRD, S_VCHK
  } state_t;

  state_t          state_r;
  logic [NW:0]     addr_r;
  logic [NW:0]     cfg_r;
  logic [NW-1:0]   a_r, b_r, u_r, v_r;
  logic            ut_r;
  logic [CW-1:0]   ca_r, cb_r, cnt_r, k_r;
  logic [NW:0]     hopu_r, head_r, tail_r, reached_r;
  logic            seen_r;

  logic            ov_r, has_p_r, seen_o_r;
  logic [1:0]      status_r;
  logic [NW:0]     hop_o_r, reached_o_r;
  logic [NW-1:0]   pred_o_r;

  // ram ports
  logic            t_we;
  logic [TAW-1:0]  t_wa, t_ra;
  logic [NW-1:0]   t_wd, t_rd;
  logic            c_we;
  logic [NW-1:0]   c_wa, c_ra;
  logic [CW-1:0]   c_wd, c_rd;
  logic            i_we;
  logic [NW-1:0]   i_wa, i_ra;
  logic [IW-1:0]   i_wd, i_rd;
  logic            q_we;
  logic [NW-1:0]   q_wa, q_ra;
  logic [NW-1:0]   q_wd, q_rd;

  logic [NW:0]     n_act;
  logic            in_acc, bad_a, bad_b, bad;
  logic [CW-1:0]   cb_eff;
  logic [CW:0]     ca_x, cb_x;
  logic            full;
  logic [NW:0]     i_hop;
  logic [NW-1:0]   i_pred;
  logic            i_pv;

  hcgs_ram #(.WIDTH(NW), .DEPTH(TD)) u_table (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  hcgs_ram #(.WIDTH(CW), .DEPTH(NODES)) u_counts (
    .clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  hcgs_ram #(.WIDTH(IW), .DEPTH(NODES)) u_info (
    .clk, .we(i_we), .waddr(i_wa), .wdata(i_wd), .raddr(i_ra), .rdata(i_rd));
  hcgs_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  // config register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_NODES_IN_USE) ? 32'(cfg_r) : 32'd0;

  always_comb begin
    if (cfg_r == '0) begin
      n_act = (NW+1)'(1);
    end else if (cfg_r > UNREACHED) begin
      n_act = UNREACHED;
    end else begin
      n_act = cfg_r;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE) && (!ov_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign bad_a = {1'b0, in_ch.first_node} >= n_act;
  assign bad_b = {1'b0, in_ch.second_node} >= n_act;
  always_comb begin
    case (in_ch.mode)
      MODE_ADD:    bad = bad_a || bad_b;
      MODE_SEARCH: bad = bad_a || (in_ch.use_target && bad_b);
      MODE_READ:   bad = bad_a;
      default:     bad = 1'b0;
    endcase
  end

  assign i_hop  = i_rd[NW:0];
  assign i_pred = i_rd[2*NW:NW+1];
  assign i_pv   = i_rd[IW-1];

  // edge insertion room check
  assign ca_x   = {1'b0, ca_r};
  assign cb_x   = {1'b0, c_rd};
  assign full   = (a_r == b_r) ? (ca_x + (CW+1)'(2) > MAXD)
                               : ((ca_x >= MAXD) || (cb_x >= MAXD));
  assign cb_eff = (a_r == b_r) ? CW'(ca_r + CW'(1)) : c_rd;

  always_comb begin
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
    c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
    i_we = 1'b0; i_wa = '0; i_wd = '0; i_ra = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
    case (state_r)
      S_INIT: begin
        c_we = 1'b1; c_wa = addr_r[NW-1:0];
        i_we = 1'b1; i_wa = addr_r[NW-1:0]; i_wd = {1'b0, NW'(0), UNREACHED};
      end
      S_CLR: begin
        c_we = 1'b1; c_wa = addr_r[NW-1:0];
      end
      S_E_RA: c_ra = a_r;
      S_E_RB: c_ra = b_r;
      S_E_CHK: begin
        if (!full) begin
          t_we = 1'b1;
          t_wa = TAW'(a_r) * TAW'(MAX_DEGREE) + TAW'(ca_r);
          t_wd = b_r;
          c_we = 1'b1; c_wa = a_r; c_wd = CW'(ca_r + CW'(1));
        end
      end
      S_E_W2: begin
        t_we = 1'b1;
        t_wa = TAW'(b_r) * TAW'(MAX_DEGREE) + TAW'(cb_r);
        t_wd = a_r;
        c_we = 1'b1; c_wa = b_r; c_wd = CW'(cb_r + CW'(1));
      end
      S_RD: i_ra = a_r;
      S_BFS_CLR: begin
        i_we = 1'b1; i_wa = addr_r[NW-1:0]; i_wd = {1'b0, NW'(0), UNREACHED};
      end
      S_BFS_SEED: begin
        i_we = 1'b1; i_wa = a_r; i_wd = '0;
        q_we = 1'b1; q_wa = '0; q_wd = a_r;
      end
      S_DEQ: q_ra = head_r[NW-1:0];
      S_DQW: begin
        c_ra = q_rd;
        i_ra = q_rd;
      end
      S_SCAN: t_ra = TAW'(u_r) * TAW'(MAX_DEGREE) + TAW'(k_r);
      S_VRD:  i_ra = t_rd;
      S_VCHK: begin
        if ({1'b0, v_r} < n_act && i_hop == UNREACHED) begin
          i_we = 1'b1; i_wa = v_r; i_wd = {1'b1, u_r, (NW+1)'(hopu_r + (NW+1)'(1))};
          q_we = tail_r < UNREACHED; q_wa = tail_r[NW-1:0]; q_wd = v_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      addr_r  <= '0;
      cfg_r   <= UNREACHED;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_NODES_IN_USE) begin
        cfg_r <= cfg_pwdata[NW:0];
      end
      // a rejected transaction reloads the result in the same cycle
      if (ov_r && out_ch.ready && !(in_acc && bad)) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_INIT, S_CLR, S_BFS_CLR: begin
          if (addr_r == UNREACHED - (NW+1)'(1)) begin
            addr_r <= '0;
            if (state_r == S_BFS_CLR) begin
              state_r <= S_BFS_SEED;
            end else if (state_r == S_CLR) begin
              ov_r <= 1'b1; status_r <= ST_OK; hop_o_r <= '0; pred_o_r <= '0;
              has_p_r <= 1'b0; reached_o_r <= '0; seen_o_r <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            addr_r <= addr_r + (NW+1)'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            a_r    <= in_ch.first_node;
            b_r    <= in_ch.second_node;
            ut_r   <= in_ch.use_target;
            if (bad) begin
              ov_r <= 1'b1; status_r <= ST_BAD_NODE; hop_o_r <= '0; pred_o_r <= '0;
              has_p_r <= 1'b0; reached_o_r <= '0; seen_o_r <= 1'b0;
            end else begin
              case (in_ch.mode)
                MODE_CLEAR:  state_r <= S_CLR;
                MODE_ADD:    state_r <= S_E_RA;
                MODE_SEARCH: state_r <= S_BFS_CLR;
                MODE_READ:   state_r <= S_RD;
                default:     state_r <= S_IDLE;
              endcase
            end
          end
        end
        S_E_RA: state_r <= S_E_RB;
        S_E_RB: begin
          ca_r    <= c_rd;
          state_r <= S_E_CHK;
        end
        S_E_CHK: begin
          cb_r <= cb_eff;
          if (full) begin
            ov_r <= 1'b1; status_r <= ST_FULL; hop_o_r <= '0; pred_o_r <= '0;
            has_p_r <= 1'b0; reached_o_r <= '0; seen_o_r <= 1'b0;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_E_W2;
          end
        end
        S_E_W2: begin
          ov_r <= 1'b1; status_r <= ST_OK; hop_o_r <= '0; pred_o_r <= '0;
          has_p_r <= 1'b0; reached_o_r <= '0; seen_o_r <= 1'b0;
          state_r <= S_IDLE;
        end
        S_RD: state_r <= S_RD_W;
        S_RD_W: begin
          ov_r <= 1'b1; status_r <= ST_OK; hop_o_r <= i_hop;
          pred_o_r <= i_pv ? i_pred : '0; has_p_r <= i_pv;
          reached_o_r <= '0; seen_o_r <= 1'b0;
          state_r <= S_IDLE;
        end
        S_BFS_SEED: begin
          head_r    <= '0;
          tail_r    <= (NW+1)'(1);
          reached_r <= (NW+1)'(1);
          seen_r    <= 1'b0;
          state_r   <= S_DEQ;
        end
        S_DEQ: begin
          if (head_r == tail_r || seen_r) begin
            ov_r <= 1'b1; status_r <= ST_OK; hop_o_r <= '0; pred_o_r <= '0;
            has_p_r <= 1'b0; reached_o_r <= reached_r; seen_o_r <= seen_r;
            state_r <= S_IDLE;
          end else begin
            head_r  <= head_r + (NW+1)'(1);
            state_r <= S_DQW;
          end
        end
        S_DQW: begin
          u_r     <= q_rd;
          state_r <= S_UW;
        end
        S_UW: begin
          cnt_r   <= ({1'b0, c_rd} > MAXD) ? CW'(MAX_DEGREE) : c_rd;
          hopu_r  <= i_hop;
          k_r     <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: state_r <= (k_r == cnt_r) ? S_DEQ : S_VRD;
        S_VRD: begin
          v_r     <= t_rd;
          state_r <= S_VCHK;
        end
        S_VCHK: begin
          if ({1'b0, v_r} < n_act) begin
            if (i_hop == UNREACHED) begin
              if (tail_r < UNREACHED) begin
                tail_r <= tail_r + (NW+1)'(1);
              end
              reached_r <= reached_r + (NW+1)'(1);
            end
            if (ut_r && v_r == b_r) begin
              seen_r <= 1'b1;
            end
          end
          k_r     <= k_r + CW'(1);
          state_r <= S_SCAN;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.status          = status_r;
  assign out_ch.hop_count       = hop_o_r;
  assign out_ch.predecessor     = pred_o_r;
  assign out_ch.has_predecessor = has_p_r;
  assign out_ch.reached_count   = reached_o_r;
  assign out_ch.target_seen     = seen_o_r;

endmodule

// File: rtl/core/hcgs_checker.sv
// hcgs_checker: port-level assertions for hop_count_graph_search, and its bind
// depends on hcgs_pkg and the top level's ports

module hcgs_checker
  import hcgs_pkg::*;
#(
  parameter int NW = 10
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [1:0]    status,
  input logic [NW:0]   hop_count,
  input logic [NW:0]   reached_count,
  input logic          has_predecessor,
  input logic          cfg_pready
);

  // one transaction in flight: no new item while a result is stuck
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!out_valid || out_ready))
    else $error("input taken while result stalled");

  // a rejected transaction answers at once, any other keeps ready low
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready || out_valid))
    else $error("ready high right after accepting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(hop_count)))
    else $error("stalled result changed");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != ST_OK) |->
      (hop_count == '0 && reached_count == '0 && !has_predecessor))
    else $error("error result carries data");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind hop_count_graph_search hcgs_checker #(.NW($clog2(NODES))) u_hcgs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .status          (out_ch.status),
  .hop_count       (out_ch.hop_count),
  .reached_count   (out_ch.reached_count),
  .has_predecessor (out_ch.has_predecessor),
  .cfg_pready      (cfg_pready)
);

// File: test/testbench.sv
// testbench: self-checking bench for hop_count_graph_search, with a directed table and
// then random phases; results are checked against a built-in graph search predictor or typed rows
// depends on hcgs_pkg, hcgs_if.sv and the hop_count_graph_search rtl
`timescale 1ns / 1ps

module testbench;
  import hcgs_pkg::*;

  localparam int NODES     = NODES_DEF;
  localparam int DEG       = MAX_DEGREE_DEF;
  localparam int UNREACHED = NODES;
  localparam int WDOG_MAX  = 200000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [1:0] mode;
    logic [9:0] first_node;
    logic [9:0] second_node;
    logic       use_target;
  } graph_op_t;

  typedef struct {
    logic [1:0]  status;
    logic [10:0] hop_count;
    logic [9:0]  predecessor;
    logic        has_predecessor;
    logic [10:0] reached_count;
    logic        target_seen;
  } graph_res_t;

  typedef struct {
    bit          is_cfg;
    logic [10:0] cfg_val;
    graph_op_t   op;
    bit          typed;
    graph_res_t  res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  hcgs_in_if  #(.NODE_W(10)) in_ch();
  hcgs_out_if #(.NODE_W(10)) out_ch();

  hop_count_graph_search dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [9:0]  nbr_list [NODES][DEG];
  int          nbr_cnt  [NODES];
  int          hops     [NODES];
  logic [9:0]  pred_of  [NODES];
  bit          pred_ok  [NODES];
  logic [10:0] node_limit_reg;

  graph_res_t  pending_results[$];
  table_row_t  dir_rows[$];
  int          err_count;
  int          ops_sent, searches_run, results_seen;
  bit          no_idle;
  bit          hold_long;

  function automatic int active_nodes();
    int n;
    n = node_limit_reg;
    if (n == 0) n = 1;
    if (n > NODES) n = NODES;
    return n;
  endfunction

  function automatic graph_res_t predict_graph_op(graph_op_t op);
    graph_res_t r;
    int n, a, b, u, v, reached;
    bit seen;
    int bfs_q[$];
    r = '{default: '0};
    n = active_nodes();
    a = op.first_node;
    b = op.second_node;
    case (op.mode)
      MODE_CLEAR: begin
        foreach (nbr_cnt[i]) nbr_cnt[i] = 0;
      end
      MODE_ADD: begin
        if (a >= n || b >= n) r.status = ST_BAD_NODE;
        else if (a == b ? nbr_cnt[a] + 2 > DEG : (nbr_cnt[a] >= DEG || nbr_cnt[b] >= DEG))
          r.status = ST_FULL;
        else begin
          nbr_list[a][nbr_cnt[a]] = b[9:0];
          nbr_cnt[a]++;
          nbr_list[b][nbr_cnt[b]] = a[9:0];
          nbr_cnt[b]++;
        end
      end
      MODE_SEARCH: begin
        if (a >= n || (op.use_target && b >= n)) begin
          r.status = ST_BAD_NODE;
        end else begin
          searches_run++;
          foreach (hops[i]) begin
            hops[i] = UNREACHED;
            pred_ok[i] = 1'b0;
          end
          hops[a] = 0;
          bfs_q.insert(bfs_q.size(), a);
          reached = 1;
          seen = 1'b0;
          while (bfs_q.size() > 0 && !seen) begin
            u = bfs_q[0];
            bfs_q.delete(0);
            for (int k = 0; k < nbr_cnt[u]; k++) begin
              v = nbr_list[u][k];
              if (v >= n) continue;  // stale entry after the node limit was lowered
              if (hops[v] == UNREACHED) begin
                hops[v] = hops[u] + 1;
                pred_of[v] = u[9:0];
                pred_ok[v] = 1'b1;
                bfs_q.insert(bfs_q.size(), v);
                reached++;
              end
              if (op.use_target && v == b) seen = 1'b1;
            end
          end
          r.reached_count = reached[10:0];
          r.target_seen = seen;
        end
      end
      default: begin
        if (a >= n) r.status = ST_BAD_NODE;
        else begin
          r.hop_count = hops[a][10:0];
          if (pred_ok[a]) begin
            r.predecessor = pred_of[a];
            r.has_predecessor = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    err_count++;
  endtask

  task automatic compare_result(graph_res_t want);
    if (out_ch.status !== want.status) report_mismatch("status", out_ch.status, want.status);
    if (out_ch.hop_count !== want.hop_count)
      report_mismatch("hop_count", out_ch.hop_count, want.hop_count);
    if (out_ch.predecessor !== want.predecessor)
      report_mismatch("predecessor", out_ch.predecessor, want.predecessor);
    if (out_ch.has_predecessor !== want.has_predecessor)
      report_mismatch("has_predecessor", out_ch.has_predecessor, want.has_predecessor);
    if (out_ch.reached_count !== want.reached_count)
      report_mismatch("reached_count", out_ch.reached_count, want.reached_count);
    if (out_ch.target_seen !== want.target_seen)
      report_mismatch("target_seen", out_ch.target_seen, want.target_seen);
  endtask

  // result side: random stalls, one draw per transaction, none while no_idle, one long hold on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        stall = LONG_HOLD;
        hold_long = 1'b0;
      end else stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("result %0d arrived with nothing outstanding", results_seen);
        err_count++;
      end else begin
        compare_result(pending_results[0]);
        pending_results.delete(0);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WDOG_MAX) begin
        $display("timeout: no transaction for %0d cycles", quiet);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_op(graph_op_t op, bit typed, graph_res_t typed_res);
    int gap;
    graph_res_t want;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= op.mode;
    in_ch.first_node  <= op.first_node;
    in_ch.second_node <= op.second_node;
    in_ch.use_target  <= op.use_target;
    do @(posedge clk); while (!in_ch.ready);
    want = predict_graph_op(op);
    pending_results.insert(pending_results.size(), typed ? typed_res : want);
    ops_sent++;
  endtask

  // lowers valid in the step of the last acceptance, then waits for all results
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_node_limit(logic [10:0] val);
    drain();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= REG_NODES_IN_USE;
    cfg_pwdata  <= {21'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    node_limit_reg = val;
    @(posedge clk);
  endtask

  task automatic add_row(logic [1:0] m, int a, int b, bit t);
    dir_rows.insert(dir_rows.size(),
                    '{0, 11'd0, '{m, a[9:0], b[9:0], t}, 0, '{default: '0}});
  endtask

  task automatic add_typed(logic [1:0] m, int a, int b, bit t,
                           logic [1:0] st, int hop, int reached);
    dir_rows.insert(dir_rows.size(), '{0, 11'd0, '{m, a[9:0], b[9:0], t}, 1,
                    '{st, hop[10:0], 10'd0, 1'b0, reached[10:0], 1'b0}});
  endtask

  task automatic add_cfg(int val);
    dir_rows.insert(dir_rows.size(),
                    '{1, val[10:0], '{MODE_CLEAR, 10'd0, 10'd0, 1'b0}, 0, '{default: '0}});
  endtask

  function automatic logic [9:0] pick_node(int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 10'($urandom_range(0, (n < 16 ? n : 16) - 1));
    if (r < 95) return 10'($urandom_range(0, n - 1));
    return 10'($urandom_range(0, 1023));
  endfunction

  task automatic random_phase(int count);
    graph_op_t op;
    int r, n;
    for (int i = 0; i < count; i++) begin
      n = active_nodes();
      r = $urandom_range(0, 99);
      if (r < 45) op.mode = MODE_ADD;
      else if (r < 65) op.mode = MODE_SEARCH;
      else if (r < 95) op.mode = MODE_READ;
      else op.mode = MODE_CLEAR;
      op.first_node  = pick_node(n);
      op.second_node = pick_node(n);
      op.use_target  = 1'($urandom_range(0, 1));
      send_op(op, 0, '{default: '0});
    end
  endtask

  initial begin
    logic [10:0] limits [6];
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MODE_CLEAR;
    in_ch.first_node  <= '0;
    in_ch.second_node <= '0;
    in_ch.use_target  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    err_count = 0;
    ops_sent = 0;
    searches_run = 0;
    results_seen = 0;
    no_idle = 1'b0;
    hold_long = 1'b0;
    node_limit_reg = 11'd1024;
    foreach (nbr_cnt[i]) begin
      nbr_cnt[i] = 0;
      hops[i] = UNREACHED;
      pred_ok[i] = 1'b0;
      pred_of[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    add_typed(MODE_READ, 1023, 0, 0, ST_OK, 1024, 0);
    add_typed(MODE_READ, 0, 1023, 1, ST_OK, 1024, 0);
    add_row(MODE_ADD, 0, 1, 0);
    add_row(MODE_ADD, 1, 2, 0);
    add_row(MODE_ADD, 2, 3, 0);
    add_row(MODE_ADD, 3, 3, 0);           // self-loop
    add_row(MODE_ADD, 0, 1, 0);           // duplicate edge
    add_row(MODE_SEARCH, 0, 3, 1);
    add_row(MODE_READ, 3, 0, 0);
    add_row(MODE_READ, 1, 0, 0);
    add_typed(MODE_SEARCH, 1023, 0, 0, ST_OK, 0, 1);   // isolated source
    add_typed(MODE_READ, 1023, 0, 0, ST_OK, 0, 0);
    add_row(MODE_SEARCH, 5, 5, 1);        // source as target, no self edge
    add_row(MODE_ADD, 5, 5, 0);
    add_row(MODE_SEARCH, 5, 5, 1);
    add_typed(MODE_CLEAR, 0, 0, 0, ST_OK, 0, 0);
    add_row(MODE_READ, 5, 0, 0);          // results survive a clear
    add_row(MODE_ADD, 1, 9, 0);
    add_row(MODE_ADD, 1, 2, 0);
    add_cfg(4);
    add_row(MODE_SEARCH, 1, 0, 0);        // node 9 now stale
    add_typed(MODE_ADD, 0, 4, 0, ST_BAD_NODE, 0, 0);
    add_typed(MODE_SEARCH, 0, 1023, 1, ST_BAD_NODE, 0, 0);
    add_typed(MODE_READ, 4, 0, 0, ST_BAD_NODE, 0, 0);
    repeat (3) add_row(MODE_ADD, 2, 2, 0);
    add_typed(MODE_ADD, 2, 2, 0, ST_FULL, 0, 0);   // self-loop with one entry left

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_node_limit(dir_rows[i].cfg_val);
      else send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].res);
    end

    // random phases over several node limits, extremes included
    limits = '{11'd2047, 11'd16, 11'd0, 11'd1, 11'd300, 11'd1024};
    foreach (limits[p]) begin
      write_node_limit(limits[p]);
      no_idle = (p == 1);
      if (p == 5) hold_long = 1'b1;  // receiver holds off while items keep coming
      random_phase(12);
    end
    no_idle = 1'b0;
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d graph operations, %0d searches, %0d results checked",
             ops_sent, searches_run, results_seen);
    $display("node limits swept from 0 to 2047 with random stalls on both channels");
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
